// ----- sv/priority_job_table_top_macros.svh -----
// Assertion macros used by the port-level checker of the priority job table.
// No dependencies; each macro expects clk and rst in the enclosing scope.
`ifndef PRIORITY_JOB_TABLE_TOP_MACROS_SVH
`define PRIORITY_JOB_TABLE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PJT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PJT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pjt_pkg.sv -----
// Shared types and constants of the priority job table.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package pjt_pkg;

  localparam int DEPTH   = 16;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int PRI_W   = 8;
  localparam int ENTRY_W = ID_W + PRI_W;
  localparam int CAP_W   = 5;
  localparam int HELD_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_EXEC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_RAN   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic add;
    logic empty_exec;
    logic start;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_entry;
  } dp_status_t;

endpackage

// ----- sv/pjt_ctrl.sv -----
// Controller of the priority job table: sequences adds and execute scans.
// Depends on pjt_pkg; drives the datapath through dp_cmd_t.
module pjt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  output logic                out_valid,
  input  logic                out_ready,
  input  pjt_pkg::dp_status_t sts,
  output pjt_pkg::dp_cmd_t    cmd
);
  import pjt_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && op == OP_EXEC && !sts.count_zero) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.last_entry) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready       = out_free;
        cmd.add        = accept && op == OP_ADD;
        cmd.empty_exec = accept && op == OP_EXEC && sts.count_zero;
        cmd.start      = accept && op == OP_EXEC && !sts.count_zero;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.add || cmd.empty_exec || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/pjt_datapath.sv -----
// Datapath of the priority job table: job memory, counters, top priority, result register.
// Depends on pjt_pkg; commanded by pjt_ctrl.
module pjt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [pjt_pkg::CAP_W-1:0]    cfg_write_data,
  input  logic [pjt_pkg::ID_W-1:0]     proc_id,
  input  logic [pjt_pkg::PRI_W-1:0]    priority_req,
  input  pjt_pkg::dp_cmd_t             cmd,
  output pjt_pkg::dp_status_t          sts,
  output logic [pjt_pkg::STATUS_W-1:0] status,
  output logic [pjt_pkg::ID_W-1:0]     run_id,
  output logic [pjt_pkg::PRI_W-1:0]    run_priority,
  output logic [pjt_pkg::HELD_W-1:0]   jobs_held
);
  import pjt_pkg::*;

  localparam int MEM_WORDS = 2 * (1 << ADDR_W);
  localparam int LIM_W     = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

  // Two banks: the live order sits in one, an execute compacts into the other.
  logic [ENTRY_W-1:0] mem [MEM_WORDS];
  logic [ADDR_W:0]    wr_addr;
  logic [ADDR_W:0]    rd_addr;
  logic               wr_en;
  logic               rd_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  logic               order_reversed;
  logic [CAP_W-1:0]   capacity;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_m1;
  logic               top_valid;
  logic [PRI_W-1:0]   top_pri;
  logic [ADDR_W-1:0]  scan_idx;
  logic [COUNT_W-1:0] kept_n;
  logic               taken;
  logic [ID_W-1:0]    take_id;
  logic [PRI_W-1:0]   take_pri;
  logic               new_valid;
  logic [PRI_W-1:0]   new_pri;

  logic               full;
  logic               hit;
  logic [PRI_W-1:0]   rd_pri;
  logic [ID_W-1:0]    rd_id;

  assign rd_pri   = rd_data[PRI_W-1:0];
  assign rd_id    = rd_data[ENTRY_W-1:PRI_W];
  assign count_m1 = count - COUNT_W'(1);
  assign full     = (LIM_W'(count) >= LIM_W'(capacity)) || (LIM_W'(count) >= LIM_W'(DEPTH));
  // The first entry at the top priority seen while walking down is the one run.
  assign hit      = !taken && top_valid && (rd_pri == top_pri);

  assign sts.count_zero = (count == '0);
  assign sts.last_entry = (scan_idx == '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {order_reversed, count[ADDR_W-1:0]};
    wr_data = {proc_id, priority_req};
    rd_en   = 1'b0;
    rd_addr = {order_reversed, count_m1[ADDR_W-1:0]};
    if (cmd.add && !full) begin
      wr_en = 1'b1;
    end
    if (cmd.start) begin
      rd_en = 1'b1;
    end
    if (cmd.step) begin
      wr_en   = !hit;
      wr_addr = {!order_reversed, kept_n[ADDR_W-1:0]};
      wr_data = rd_data;
      rd_en   = !sts.last_entry;
      rd_addr = {order_reversed, scan_idx - ADDR_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_reversed <= 1'b0;
      capacity       <= CAP_RESET;
      count          <= '0;
      top_valid      <= 1'b0;
      top_pri        <= '0;
      scan_idx       <= '0;
      kept_n         <= '0;
      taken          <= 1'b0;
      new_valid      <= 1'b0;
      new_pri        <= '0;
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (cmd.add && !full) begin
        count <= count + COUNT_W'(1);
        if (!top_valid || priority_req > top_pri) begin
          top_valid <= 1'b1;
          top_pri   <= priority_req;
        end
      end
      if (cmd.start) begin
        scan_idx  <= count_m1[ADDR_W-1:0];
        kept_n    <= '0;
        taken     <= 1'b0;
        new_valid <= 1'b0;
      end
      if (cmd.step) begin
        scan_idx <= scan_idx - ADDR_W'(1);
        if (hit) begin
          taken <= 1'b1;
        end else begin
          kept_n <= kept_n + COUNT_W'(1);
          if (!new_valid || rd_pri > new_pri) begin
            new_valid <= 1'b1;
            new_pri   <= rd_pri;
          end
        end
      end
      if (cmd.finish) begin
        count          <= kept_n;
        top_valid      <= new_valid;
        top_pri        <= new_pri;
        order_reversed <= !order_reversed;
      end
    end
  end

  // The job taken during the scan; payload only.
  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      take_id  <= rd_id;
      take_pri <= rd_pri;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      status       <= full ? ST_FULL : ST_ADDED;
      run_id       <= '0;
      run_priority <= '0;
      jobs_held    <= full ? HELD_W'(count) : HELD_W'(count + COUNT_W'(1));
    end else if (cmd.empty_exec) begin
      status       <= ST_EMPTY;
      run_id       <= '0;
      run_priority <= '0;
      jobs_held    <= HELD_W'(count);
    end else if (cmd.finish) begin
      status       <= ST_RAN;
      run_id       <= take_id;
      run_priority <= take_pri;
      jobs_held    <= HELD_W'(kept_n);
    end
  end

endmodule

// ----- sv/priority_job_table_top.sv -----
// Priority job table: a small table of jobs with add and execute-highest requests.
// Top level; depends on pjt_pkg, pjt_ctrl and pjt_datapath.
//
// An add, or an execute on an empty table, is taken while the table is idle, and its
// result sits in the output register from the next cycle on. An execute first starts
// the read of the job memory, then walks the held jobs from the last one down, taking
// the first job at the top priority and copying every other job in walk order into
// the spare bank, and then, once the output register is free, publishes the result
// and swaps banks. A new item is taken only while the table is idle and the output
// register is empty or being emptied in the same cycle. The memory needs no clearing
// after reset, since only written slots are ever read.
module priority_job_table_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [pjt_pkg::CAP_W-1:0]    cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [pjt_pkg::ID_W-1:0]     proc_id,
  input  logic [pjt_pkg::PRI_W-1:0]    priority_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pjt_pkg::STATUS_W-1:0] status,
  output logic [pjt_pkg::ID_W-1:0]     run_id,
  output logic [pjt_pkg::PRI_W-1:0]    run_priority,
  output logic [pjt_pkg::HELD_W-1:0]   jobs_held
);
  import pjt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  pjt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pjt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .proc_id        (proc_id),
    .priority_req   (priority_req),
    .cmd            (cmd),
    .sts            (sts),
    .status         (status),
    .run_id         (run_id),
    .run_priority   (run_priority),
    .jobs_held      (jobs_held)
  );

endmodule

// ----- sv/pjt_checker.sv -----
// Port-level checker of the priority job table, bound to the top level.
// Depends on pjt_pkg and priority_job_table_top_macros.svh.
`include "priority_job_table_top_macros.svh"

module pjt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pjt_pkg::STATUS_W-1:0] status,
  input logic [pjt_pkg::ID_W-1:0]     run_id,
  input logic [pjt_pkg::PRI_W-1:0]    run_priority,
  input logic [pjt_pkg::HELD_W-1:0]   jobs_held
);
  import pjt_pkg::*;

  // A result that is not taken must stay put.
  `PJT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(status) && $stable(run_id) &&
                   $stable(run_priority) && $stable(jobs_held),
                   "stalled result changed")

  // Only an executed job reports an identifier and a priority.
  `PJT_ASSERT_SAME(a_run_zero, out_valid && status != ST_RAN,
                   run_id == '0 && run_priority == '0,
                   "run fields set without an execute")

  // Nothing to execute means the table is empty.
  `PJT_ASSERT_SAME(a_empty_count, out_valid && status == ST_EMPTY, jobs_held == '0,
                   "empty execute with jobs held")

  // A successful add leaves at least one job and never more than the depth.
  `PJT_ASSERT_SAME(a_added_count, out_valid && status == ST_ADDED,
                   jobs_held != '0 && jobs_held <= HELD_W'(DEPTH),
                   "job count out of range after add")

endmodule

bind priority_job_table_top pjt_checker u_pjt_checker (.*);

// ----- tb/pjt_job_checker.sv -----
// Checker for the priority job table: watches the request, result and configuration ports,
// predicts every result and compares it. Depends on pjt_pkg for widths, op and status codes.
module pjt_job_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [pjt_pkg::CAP_W-1:0]    cfg_write_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         op,
  input  logic [pjt_pkg::ID_W-1:0]     proc_id,
  input  logic [pjt_pkg::PRI_W-1:0]    priority_req,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [pjt_pkg::STATUS_W-1:0] status,
  input  logic [pjt_pkg::ID_W-1:0]     run_id,
  input  logic [pjt_pkg::PRI_W-1:0]    run_priority,
  input  logic [pjt_pkg::HELD_W-1:0]   jobs_held,
  output int                           pending_results,
  output int                           results_checked,
  output int                           fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pjt_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     run_id;
    logic [PRI_W-1:0]    run_pri;
    logic [HELD_W-1:0]   held;
  } job_result_t;

  // Shadow copy of the job table, kept in the block's current order from slot 0.
  logic [ID_W-1:0]  tab_id  [DEPTH];
  logic [PRI_W-1:0] tab_pri [DEPTH];
  int               held_jobs;
  int               top_pri;
  bit               order_flip;
  logic [CAP_W-1:0] capacity;

  job_result_t awaited_results[$];
  int          mismatches;
  int          checked;

  function automatic job_result_t schedule_job(input logic req_op,
                                               input logic [ID_W-1:0] req_id,
                                               input logic [PRI_W-1:0] req_pri);
    job_result_t      r;
    logic [ID_W-1:0]  kept_id  [DEPTH];
    logic [PRI_W-1:0] kept_pri [DEPTH];
    int               n;
    int               new_top;
    int               limit;
    int               i;
    bit               taken;
    r.status  = ST_ADDED;
    r.run_id  = '0;
    r.run_pri = '0;
    limit = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    if (req_op == OP_ADD) begin
      if (held_jobs >= limit) begin
        r.status = ST_FULL;
      end else begin
        tab_id[held_jobs]  = req_id;
        tab_pri[held_jobs] = req_pri;
        held_jobs++;
        if (int'(req_pri) > top_pri) top_pri = int'(req_pri);
      end
    end else if (held_jobs == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Walk from the last job down; the first job at the top priority runs and
      // the others are kept in walk order, which reverses the table.
      n = 0;
      taken = 1'b0;
      new_top = -1;
      for (i = held_jobs - 1; i >= 0; i--) begin
        if (!taken && int'(tab_pri[i]) == top_pri) begin
          taken     = 1'b1;
          r.run_id  = tab_id[i];
          r.run_pri = tab_pri[i];
        end else begin
          kept_id[n]  = tab_id[i];
          kept_pri[n] = tab_pri[i];
          n++;
          if (int'(tab_pri[i]) > new_top) new_top = int'(tab_pri[i]);
        end
      end
      for (i = 0; i < n; i++) begin
        tab_id[i]  = kept_id[i];
        tab_pri[i] = kept_pri[i];
      end
      held_jobs  = n;
      top_pri    = new_top;
      order_flip = ~order_flip;
      r.status   = ST_RAN;
    end
    r.held = HELD_W'(held_jobs);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    job_result_t want;
    if (rst) begin
      awaited_results.delete();
      held_jobs  = 0;
      top_pri    = -1;
      order_flip = 1'b0;
      capacity   = CAP_RESET;
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_write_en) capacity = cfg_write_data;
      // The outgoing result is checked before a request taken at the same edge is
      // predicted, since it can only belong to an older request.
      if (out_valid && out_ready) begin
        checked++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request waiting: status %0d id %h pri %h held %0d",
                     $realtime, status, run_id, run_priority, jobs_held);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status || run_id !== want.run_id ||
              run_priority !== want.run_pri || jobs_held !== want.held) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: expected status %0d id %h pri %h held %0d",
                       $realtime, want.status, want.run_id, want.run_pri, want.held);
              $display("%0t:                       got status %0d id %h pri %h held %0d",
                       $realtime, status, run_id, run_priority, jobs_held);
            end
          end
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(schedule_job(op, proc_id, priority_req));
    end
    pending_results <= awaited_results.size();
    results_checked <= checked;
    fail_count      <= mismatches;
  end

endmodule

// ----- tb/priority_job_table_top_tb.sv -----
// Testbench top for the priority job table: clock, reset, requests, capacity settings,
// result back-pressure and the verdict. Depends on pjt_pkg, the top level and pjt_job_checker.
module priority_job_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pjt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 9;
  // A negative capacity means a random one is picked when the phase starts.
  localparam int PHASE_CAP [NUM_PHASES] = '{16, 31, 3, 0, 1, 17, -1, -1, 16};
  localparam int PHASE_LEN [NUM_PHASES] = '{120, 120, 100, 30, 80, 120, 100, 100, 100};

  logic                clk;
  logic                rst            = 1'b1;
  logic                cfg_write_en   = 1'b0;
  logic [CAP_W-1:0]    cfg_write_data = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                op             = OP_ADD;
  logic [ID_W-1:0]     proc_id        = '0;
  logic [PRI_W-1:0]    priority_req   = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     run_id;
  logic [PRI_W-1:0]    run_priority;
  logic [HELD_W-1:0]   jobs_held;

  int pending_results;
  int results_checked;
  int fail_count;
  int cycle_count = 0;
  int adds_sent   = 0;
  int execs_sent  = 0;
  int cap_writes  = 0;
  bit idling_on   = 1'b1;

  priority_job_table_top uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .proc_id        (proc_id),
    .priority_req   (priority_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .run_id         (run_id),
    .run_priority   (run_priority),
    .jobs_held      (jobs_held)
  );

  pjt_job_checker u_job_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .proc_id         (proc_id),
    .priority_req    (priority_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .run_id          (run_id),
    .run_priority    (run_priority),
    .jobs_held       (jobs_held),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .fail_count      (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= idling_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results);
      $display("priority_job_table_top_tb NOT OK");
      $finish;
    end
  end

  // Present one request and hold it until it is taken. Valid is left high when the
  // next request follows at once, so valid gets a single update per edge.
  task automatic offer_request(input logic req_op, input logic [ID_W-1:0] req_id,
                               input logic [PRI_W-1:0] req_pri);
    in_valid     <= 1'b1;
    op           <= req_op;
    proc_id      <= req_id;
    priority_req <= req_pri;
    do @(posedge clk); while (!in_ready);
    if (req_op == OP_ADD) adds_sent++;
    else execs_sent++;
    while (idling_on && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result taken so far has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_for_drain();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cap_writes++;
  endtask

  initial begin : stimulus
    int                 add_pct;
    int                 cap;
    logic               req_op;
    logic [PRI_W-1:0]   req_pri;
    while (rst) @(posedge clk);

    // Directed part: empty table, extreme ids and priorities, ties at the top,
    // a full table, capacity lowered under the held count, and capacity zero.
    write_capacity(5'd16);
    offer_request(OP_EXEC, 16'h0000, 8'h00);
    offer_request(OP_ADD,  16'h0000, 8'h00);
    offer_request(OP_ADD,  16'hFFFF, 8'hFF);
    offer_request(OP_ADD,  16'h00FF, 8'hFF);
    offer_request(OP_ADD,  16'hFF00, 8'h80);
    offer_request(OP_EXEC, 16'hFFFF, 8'hFF);
    offer_request(OP_EXEC, 16'h0000, 8'h00);
    offer_request(OP_EXEC, 16'hAAAA, 8'h55);
    offer_request(OP_EXEC, 16'h5555, 8'hAA);
    offer_request(OP_EXEC, 16'h0000, 8'h00);
    write_capacity(5'd2);
    offer_request(OP_ADD,  16'hA5A5, 8'h01);
    offer_request(OP_ADD,  16'h5A5A, 8'h02);
    offer_request(OP_ADD,  16'h1111, 8'h03);
    write_capacity(5'd1);
    offer_request(OP_ADD,  16'h3333, 8'h04);
    offer_request(OP_EXEC, 16'h0000, 8'h00);
    offer_request(OP_ADD,  16'h4444, 8'h05);
    offer_request(OP_EXEC, 16'h0000, 8'h00);
    offer_request(OP_ADD,  16'h2222, 8'h07);
    offer_request(OP_EXEC, 16'h0000, 8'h00);
    write_capacity(5'd0);
    offer_request(OP_ADD,  16'h7FFF, 8'h7F);
    offer_request(OP_EXEC, 16'h0000, 8'h00);

    // Random part: one capacity per phase, jobs left in the table across phases.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      cap = (PHASE_CAP[phase] < 0) ? $urandom_range(0, 31) : PHASE_CAP[phase];
      write_capacity(CAP_W'(cap));
      // The second phase runs with no gaps on either side and fills the table.
      idling_on = (phase != 1);
      add_pct = (phase == 1) ? 75 : $urandom_range(45, 70);
      for (int k = 0; k < PHASE_LEN[phase]; k++) begin
        req_op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_EXEC;
        // Narrow priorities make ties at the top common.
        case ($urandom_range(0, 3))
          0:       req_pri = PRI_W'($urandom_range(0, 3));
          1:       req_pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: req_pri = PRI_W'($urandom_range(0, 255));
        endcase
        offer_request(req_op, ID_W'($urandom_range(0, 65535)), req_pri);
      end
    end

    idling_on = 1'b1;
    wait_for_drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d adds and %0d executes under %0d capacity writes,",
             adds_sent, execs_sent, cap_writes);
    $display("full and empty cases included; checked %0d results, %0d of them wrong.",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("priority_job_table_top_tb OK");
    end else begin
      $display("priority_job_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule
